// ===== src/gmd_pkg.sv =====
// Shared types and codes for the gRPC message deframer.
`default_nettype none

package gmd_pkg;

    localparam logic [2:0] HDR_BYTES   = 3'd5;
    localparam logic [2:0] HDR_LAST    = 3'd4;

    localparam logic [2:0] K_BYTE      = 3'd0;
    localparam logic [2:0] K_EMPTY     = 3'd1;
    localparam logic [2:0] K_END_OK    = 3'd2;
    localparam logic [2:0] K_END_TRUNC = 3'd3;
    localparam logic [2:0] K_COMP_ERR  = 3'd4;

    localparam logic       REQ_DATA    = 1'b0;
    localparam logic       REQ_END     = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_ERROR   = 3'b100
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload_byte;
        logic       last_of_message;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/grpc_message_deframer_core.sv =====
// Streaming deframer for length-prefixed gRPC messages in a request body.
//
// Input channel (s_): one item per body byte (req_type 0) or one item that
// marks the end of the request body (req_type 1).
// Result channel (m_): payload bytes with the last byte of each message
// marked, empty-message markers, and one end status per request (ok,
// truncated, compression error). Header bytes other than the last of an empty
// message's header and bytes dropped after a compression error give no result.
// Each accepted item goes into an input register; counter and compare logic
// against the framing state then fills the result register, which drives
// m_valid. Throughput is one item per cycle while m_ready allows it, set by
// the single pass through the input and result registers; the end-of-request
// case clears the state in the same pass.
// When the receiver stalls, the result register holds and the input
// register still accepts one more item; s_ready drops once both are full.
// A synchronous low aresetn empties both registers and returns the framing
// state to header collection.
`default_nettype none

module grpc_message_deframer_core
    import gmd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic        in_valid_reg, in_valid_next;
    in_item_t    in_item_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    phase_t      phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  flag_byte_reg, flag_byte_next;
    logic [31:0] length_shift_reg, length_shift_next;
    logic [31:0] bytes_remaining_reg, bytes_remaining_next;

    logic        advance;
    logic        emit;
    logic [31:0] length_full;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assign length_full = {length_shift_reg[23:0], in_item_reg.byte_in};

    always_comb begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        flag_byte_next       = flag_byte_reg;
        length_shift_next    = length_shift_reg;
        bytes_remaining_next = bytes_remaining_reg;
        emit                 = 1'b0;
        out_item_next        = '0;

        if (in_item_reg.req_type == REQ_END) begin
            emit = 1'b1;
            if (phase_reg == PH_ERROR) begin
                out_item_next.kind = K_COMP_ERR;
            end else if (phase_reg == PH_PAYLOAD || header_count_reg != 3'd0) begin
                out_item_next.kind = K_END_TRUNC;
            end else begin
                out_item_next.kind = K_END_OK;
            end
            phase_next           = PH_HEADER;
            header_count_next    = '0;
            flag_byte_next       = '0;
            length_shift_next    = '0;
            bytes_remaining_next = '0;
        end else begin
            case (phase_reg)
                PH_ERROR: begin
                    // drop data bytes until end of request
                end
                PH_PAYLOAD: begin
                    emit                          = 1'b1;
                    out_item_next.kind            = K_BYTE;
                    out_item_next.payload_byte    = in_item_reg.byte_in;
                    bytes_remaining_next          = bytes_remaining_reg - 32'd1;
                    if (bytes_remaining_reg == 32'd1) begin
                        out_item_next.last_of_message = 1'b1;
                        phase_next           = PH_HEADER;
                        header_count_next    = '0;
                        flag_byte_next       = '0;
                        length_shift_next    = '0;
                        bytes_remaining_next = '0;
                    end
                end
                default: begin
                    // collect header; an unknown phase behaves as header
                    phase_next = PH_HEADER;
                    if (header_count_reg == 3'd0) begin
                        flag_byte_next = in_item_reg.byte_in;
                    end else begin
                        length_shift_next = length_full;
                    end
                    header_count_next = header_count_reg + 3'd1;
                    if (header_count_reg == HDR_LAST) begin
                        header_count_next = '0;
                        if (flag_byte_reg != 8'd0) begin
                            phase_next = PH_ERROR;
                        end else if (length_full == 32'd0) begin
                            emit                          = 1'b1;
                            out_item_next.kind            = K_EMPTY;
                            out_item_next.last_of_message = 1'b1;
                            flag_byte_next       = '0;
                            length_shift_next    = '0;
                            bytes_remaining_next = '0;
                        end else begin
                            bytes_remaining_next = length_full;
                            length_shift_next    = '0;
                            flag_byte_next       = '0;
                            phase_next           = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            phase_reg           <= PH_HEADER;
            header_count_reg    <= '0;
            flag_byte_reg       <= '0;
            length_shift_reg    <= '0;
            bytes_remaining_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg           <= phase_next;
                header_count_reg    <= header_count_next;
                flag_byte_reg       <= flag_byte_next;
                length_shift_reg    <= length_shift_next;
                bytes_remaining_reg <= bytes_remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && emit) begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.req_type == REQ_END) |=>
            (phase_reg == PH_HEADER && header_count_reg == 3'd0))
        else $error("end of request did not clear framing state");

    a_payload_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (bytes_remaining_reg != 32'd0))
        else $error("payload phase with no bytes owed");

    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (header_count_reg <= HDR_LAST))
        else $error("header count beyond header length");

    a_status_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.kind != K_BYTE) |-> (m_item.payload_byte == 8'd0))
        else $error("non-payload item carries a byte");
`endif

endmodule

`default_nettype wire
